FILE: hw/rtl/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg: shared types and constants of the sorted priority queue
// Operation and status codes, cell control struct and field widths.
// ----------------------------------------------------------------------------
package spq_pkg;

    localparam int DATA_W           = 32;
    localparam int OP_W             = 2;
    localparam int STATUS_W         = 2;
    localparam int POS_W            = 4;
    localparam int COUNT_W          = 5;
    localparam int DEFAULT_CAPACITY = 16;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_FIND   = 2'd2,
        OP_PEEK   = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK        = 2'd0,
        STATUS_NOT_FOUND = 2'd1,
        STATUS_FULL      = 2'd2
    } status_t;

    typedef enum logic {
        ST_IDLE   = 1'b0,
        ST_UPDATE = 1'b1
    } state_t;

    typedef enum logic [1:0] {
        UPD_NONE   = 2'd0,
        UPD_INSERT = 2'd1,
        UPD_REMOVE = 2'd2
    } upd_t;

    // Broadcast from the sequencer to every cell
    typedef struct packed {
        logic                     compare;
        upd_t                     upd;
        logic signed [DATA_W-1:0] value;
    } cell_ctrl_t;

endpackage

FILE: hw/rtl/spq_cmd_if.sv
// ----------------------------------------------------------------------------
// spq_cmd_if: command channel of the sorted priority queue
// Valid/ready channel carrying one operation and its value.
// ----------------------------------------------------------------------------
interface spq_cmd_if;
    logic                             valid;
    logic                             ready;
    logic [spq_pkg::OP_W-1:0]         op;
    logic signed [spq_pkg::DATA_W-1:0] value;

    modport source (output valid, output op, output value, input ready);
    modport sink   (input valid, input op, input value, output ready);
endinterface

FILE: hw/rtl/spq_res_if.sv
// ----------------------------------------------------------------------------
// spq_res_if: result channel of the sorted priority queue
// Valid/ready channel carrying status, position, head and count.
// ----------------------------------------------------------------------------
interface spq_res_if;
    logic                              valid;
    logic                              ready;
    logic [spq_pkg::STATUS_W-1:0]      status;
    logic [spq_pkg::POS_W-1:0]         position;
    logic signed [spq_pkg::DATA_W-1:0] head_value;
    logic                              head_valid;
    logic [spq_pkg::COUNT_W-1:0]       count;

    modport source (output valid, output status, output position, output head_value,
                    output head_valid, output count, input ready);
    modport sink   (input valid, input status, input position, input head_value,
                    input head_valid, input count, output ready);
endinterface

FILE: hw/rtl/spq_cell.sv
// ----------------------------------------------------------------------------
// spq_cell: one storage cell of the sorted chain
// Holds one entry, compares it with the broadcast value and shifts to or
// from its neighbors on insert and remove.
// ----------------------------------------------------------------------------
module spq_cell
(
    input  logic                              clk,
    input  spq_pkg::cell_ctrl_t               ctrl,
    input  logic                              occupied,
    input  logic                              left_lt,
    input  logic signed [spq_pkg::DATA_W-1:0] left_entry,
    input  logic signed [spq_pkg::DATA_W-1:0] right_entry,
    output logic signed [spq_pkg::DATA_W-1:0] entry,
    output logic                              lt,
    output logic                              eq
);

    logic signed [spq_pkg::DATA_W-1:0] entry_reg;
    logic signed [spq_pkg::DATA_W-1:0] entry_next;
    logic                              lt_reg;
    logic                              lt_next;
    logic                              eq_reg;
    logic                              eq_next;

    // Compare against the broadcast value and pick the new entry
    always_comb
    begin
        lt_next    = lt_reg;
        eq_next    = eq_reg;
        entry_next = entry_reg;
        if (ctrl.compare)
        begin
            lt_next = occupied && (entry_reg < ctrl.value);
            eq_next = occupied && (entry_reg == ctrl.value);
        end
        case (ctrl.upd)
            spq_pkg::UPD_INSERT:
            begin
                // keep smaller entries, write at the boundary, shift the rest up
                if (!lt_reg)
                begin
                    entry_next = left_lt ? ctrl.value : left_entry;
                end
            end
            spq_pkg::UPD_REMOVE:
            begin
                // close the gap from the removed entry onward
                if (!lt_reg)
                begin
                    entry_next = right_entry;
                end
            end
            default:
            begin
                entry_next = entry_reg;
            end
        endcase
    end

    // Hold entry and compare flags
    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
        lt_reg    <= lt_next;
        eq_reg    <= eq_next;
    end

    assign entry = entry_reg;
    assign lt    = lt_reg;
    assign eq    = eq_reg;

endmodule

FILE: hw/rtl/sorted_priority_queue_unit.sv
// ----------------------------------------------------------------------------
// sorted_priority_queue_unit: sorted list priority queue in a chain of cells
// Keeps up to CAPACITY signed values in ascending order, head at cell 0.
// ----------------------------------------------------------------------------
// Usage:
//   cmd carries one transaction per operation: op (insert, remove, find,
//   peek) and value. result returns exactly one transaction per command
//   with status, position, head_value, head_valid and count.
//   Timing: a command is taken in the compare cycle, where every cell
//   compares its entry with the value in parallel; the update state that
//   follows encodes the boundary, shifts the cells toward or away from it
//   and loads the output register. A new command is taken only after the
//   previous one has left the update state; the compare and shift pair of
//   the cell chain sets the command rate, independent of fill level.
//   cmd.ready is high in the compare slot; a new command is taken while a
//   previous result still waits in the output register. If the receiver
//   stalls, the update cycle holds until the output register frees up.
//   Reset empties the queue (count zero) and drops any pending result;
//   the cell contents are not cleared, cells beyond count never affect a result.
// ----------------------------------------------------------------------------
module sorted_priority_queue_unit
#(
    parameter int CAPACITY = spq_pkg::DEFAULT_CAPACITY
)
(
    input  logic     clk,
    input  logic     rst_n,
    spq_cmd_if.sink   cmd,
    spq_res_if.source result
);

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);

    spq_pkg::state_t                   state_reg;
    spq_pkg::state_t                   state_next;
    spq_pkg::op_t                      op_reg;
    spq_pkg::op_t                      op_next;
    logic signed [spq_pkg::DATA_W-1:0] value_reg;
    logic signed [spq_pkg::DATA_W-1:0] value_next;
    logic [CNT_W-1:0]                  count_reg;
    logic [CNT_W-1:0]                  count_next;

    logic                              out_valid_reg;
    logic                              out_valid_next;
    spq_pkg::status_t                  out_status_reg;
    spq_pkg::status_t                  out_status_next;
    logic [spq_pkg::POS_W-1:0]         out_pos_reg;
    logic [spq_pkg::POS_W-1:0]         out_pos_next;
    logic signed [spq_pkg::DATA_W-1:0] out_head_reg;
    logic signed [spq_pkg::DATA_W-1:0] out_head_next;
    logic                              out_hvalid_reg;
    logic                              out_hvalid_next;
    logic [CNT_W-1:0]                  out_count_reg;
    logic [CNT_W-1:0]                  out_count_next;

    spq_pkg::cell_ctrl_t               ctrl;
    logic signed [spq_pkg::DATA_W-1:0] entry_w [CAPACITY];
    logic [CAPACITY-1:0]               lt_w;
    logic [CAPACITY-1:0]               eq_w;
    logic [CAPACITY-1:0]               occ_w;
    logic [CAPACITY-1:0]               first_w;

    logic                              accept;
    logic                              fire;
    logic                              full;
    logic                              found;
    logic [IDX_W-1:0]                  k_idx;
    logic signed [spq_pkg::DATA_W-1:0] head_new;

    assign accept = cmd.valid && cmd.ready;
    assign fire   = (state_reg == spq_pkg::ST_UPDATE) && (!out_valid_reg || result.ready);
    assign full   = (count_reg == CNT_W'(CAPACITY));

    // Build the cell chain
    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            logic                              left_lt;
            logic signed [spq_pkg::DATA_W-1:0] left_entry;
            logic signed [spq_pkg::DATA_W-1:0] right_entry;

            assign occ_w[gi] = (CNT_W'(gi) < count_reg);

            if (gi == 0)
            begin : g_head
                assign left_lt     = 1'b1;
                assign left_entry  = '0;
                assign first_w[gi] = !lt_w[gi];
            end
            else
            begin : g_body
                assign left_lt     = lt_w[gi-1];
                assign left_entry  = entry_w[gi-1];
                assign first_w[gi] = !lt_w[gi] && lt_w[gi-1];
            end

            if (gi == CAPACITY - 1)
            begin : g_tail
                assign right_entry = '0;
            end
            else
            begin : g_mid
                assign right_entry = entry_w[gi+1];
            end

            spq_cell u_cell
            (
                .clk         (clk),
                .ctrl        (ctrl),
                .occupied    (occ_w[gi]),
                .left_lt     (left_lt),
                .left_entry  (left_entry),
                .right_entry (right_entry),
                .entry       (entry_w[gi]),
                .lt          (lt_w[gi]),
                .eq          (eq_w[gi])
            );
        end
    endgenerate

    // Encode the one-hot boundary into an index and a match flag
    always_comb
    begin
        k_idx = '0;
        found = 1'b0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (first_w[i])
            begin
                k_idx = k_idx | IDX_W'(i);
            end
            found = found | (first_w[i] & eq_w[i]);
        end
    end

    // Sequence the operation and build the result
    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        value_next      = value_reg;
        count_next      = count_reg;
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_pos_next    = out_pos_reg;
        out_head_next   = out_head_reg;
        out_hvalid_next = out_hvalid_reg;
        out_count_next  = out_count_reg;
        head_new        = entry_w[0];

        ctrl.compare = accept;
        ctrl.value   = accept ? cmd.value : value_reg;
        ctrl.upd     = spq_pkg::UPD_NONE;

        if (out_valid_reg && result.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            spq_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    op_next    = spq_pkg::op_t'(cmd.op);
                    value_next = cmd.value;
                    state_next = spq_pkg::ST_UPDATE;
                end
            end
            spq_pkg::ST_UPDATE:
            begin
                if (fire)
                begin
                    out_status_next = spq_pkg::STATUS_OK;
                    out_pos_next    = '0;
                    unique case (op_reg)
                        spq_pkg::OP_INSERT:
                        begin
                            if (full)
                            begin
                                out_status_next = spq_pkg::STATUS_FULL;
                            end
                            else
                            begin
                                ctrl.upd   = spq_pkg::UPD_INSERT;
                                count_next = count_reg + CNT_W'(1);
                                head_new   = lt_w[0] ? entry_w[0] : value_reg;
                            end
                        end
                        spq_pkg::OP_REMOVE:
                        begin
                            if (found)
                            begin
                                ctrl.upd     = spq_pkg::UPD_REMOVE;
                                count_next   = count_reg - CNT_W'(1);
                                out_pos_next = spq_pkg::POS_W'(k_idx);
                                head_new     = (k_idx == '0) ? entry_w[1] : entry_w[0];
                            end
                            else
                            begin
                                out_status_next = spq_pkg::STATUS_NOT_FOUND;
                            end
                        end
                        spq_pkg::OP_FIND:
                        begin
                            if (found)
                            begin
                                out_pos_next = spq_pkg::POS_W'(k_idx);
                            end
                            else
                            begin
                                out_status_next = spq_pkg::STATUS_NOT_FOUND;
                            end
                        end
                        spq_pkg::OP_PEEK:
                        begin
                            head_new = entry_w[0];
                        end
                    endcase
                    out_valid_next  = 1'b1;
                    out_count_next  = count_next;
                    out_hvalid_next = (count_next != '0);
                    out_head_next   = (count_next != '0) ? head_new : '0;
                    state_next      = spq_pkg::ST_IDLE;
                end
            end
        endcase
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= spq_pkg::ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold payload
    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        value_reg      <= value_next;
        out_status_reg <= out_status_next;
        out_pos_reg    <= out_pos_next;
        out_head_reg   <= out_head_next;
        out_hvalid_reg <= out_hvalid_next;
        out_count_reg  <= out_count_next;
    end

    assign cmd.ready         = (state_reg == spq_pkg::ST_IDLE);
    assign result.valid      = out_valid_reg;
    assign result.status     = out_status_reg;
    assign result.position   = out_pos_reg;
    assign result.head_value = out_head_reg;
    assign result.head_valid = out_hvalid_reg;
    assign result.count      = spq_pkg::COUNT_W'(out_count_reg);

endmodule

FILE: hw/rtl/spq_checker.sv
// ----------------------------------------------------------------------------
// spq_checker: port-level checks of the sorted priority queue
// Watches the result channel for consistency over time.
// ----------------------------------------------------------------------------
module spq_checker
#(
    parameter int CAPACITY = spq_pkg::DEFAULT_CAPACITY
)
(
    input logic                              clk,
    input logic                              rst_n,
    input logic                              out_valid,
    input logic                              out_ready,
    input logic [spq_pkg::STATUS_W-1:0]      status,
    input logic [spq_pkg::POS_W-1:0]         position,
    input logic signed [spq_pkg::DATA_W-1:0] head_value,
    input logic                              head_valid,
    input logic [spq_pkg::COUNT_W-1:0]       count
);

    // Stalled result stays and holds its payload
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status) && $stable(position)
            && $stable(head_value) && $stable(head_valid) && $stable(count))
        else $error("result dropped or changed while stalled");

    // Head validity follows the count
    a_head_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (head_valid == (count != '0)) && (head_valid || head_value == '0))
        else $error("head_valid does not match count");

    // Full status only at capacity
    a_full: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == spq_pkg::STATUS_FULL |-> count == spq_pkg::COUNT_W'(CAPACITY))
        else $error("full status below capacity");

    // Position reported only on a match
    a_pos: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != spq_pkg::STATUS_OK |-> position == '0)
        else $error("position set without a match");

endmodule

bind sorted_priority_queue_unit spq_checker #(.CAPACITY(CAPACITY)) u_spq_checker
(
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (result.valid),
    .out_ready  (result.ready),
    .status     (result.status),
    .position   (result.position),
    .head_value (result.head_value),
    .head_valid (result.head_valid),
    .count      (result.count)
);

FILE: test/sorted_priority_queue_unit_tb.sv
// ----------------------------------------------------------------------------
// sorted_priority_queue_unit_tb: self-checking bench for the sorted queue
// Drives insert, remove, find and peek commands with random stalls on both
// channels and checks every result against a behavioral queue model.
// ----------------------------------------------------------------------------
module sorted_priority_queue_unit_tb;

    localparam int CAPACITY     = spq_pkg::DEFAULT_CAPACITY;
    localparam int RANDOM_ITEMS = 1900;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 10;

    typedef struct {
        logic                              pause;
        spq_pkg::op_t                      op;
        logic signed [spq_pkg::DATA_W-1:0] value;
    } queue_cmd_t;

    typedef struct {
        spq_pkg::status_t                  status;
        logic [spq_pkg::POS_W-1:0]         position;
        logic signed [spq_pkg::DATA_W-1:0] head_value;
        logic                              head_valid;
        logic [spq_pkg::COUNT_W-1:0]       count;
    } queue_result_t;

    logic clk;
    logic rst_n;

    spq_cmd_if cmd_ch();
    spq_res_if res_ch();

    queue_cmd_t                        cmd_backlog[$];
    queue_result_t                     expected_results[$];
    logic signed [spq_pkg::DATA_W-1:0] sorted_store[$];

    int accepted_count = 0;
    int planned_count  = 0;
    int error_count    = 0;
    int cycle_count    = 0;

    sorted_priority_queue_unit #(
        .CAPACITY (CAPACITY)
    ) i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd_ch),
        .result (res_ch)
    );

    // Generate clock and reset; hold all inputs at known values from time 0
    initial
    begin
        clk          = 1'b0;
        rst_n        = 1'b0;
        cmd_ch.valid = 1'b0;
        cmd_ch.op    = spq_pkg::OP_PEEK;
        cmd_ch.value = '0;
        res_ch.ready = 1'b0;
        fork
            forever #5 clk = ~clk;
            begin
                repeat (3) @(posedge clk);
                rst_n <= 1'b1;
            end
        join_none
    end

    // Return the index of the first stored entry equal to val, or -1
    function automatic int locate_value(logic signed [spq_pkg::DATA_W-1:0] val);
        foreach (sorted_store[i])
        begin
            if (sorted_store[i] == val)
                return i;
        end
        return -1;
    endfunction

    // Apply one operation to the queue model and return the expected result
    function automatic queue_result_t apply_queue_op(spq_pkg::op_t op,
                                                     logic signed [spq_pkg::DATA_W-1:0] val);
        queue_result_t res;
        int            k;
        res.status   = spq_pkg::STATUS_OK;
        res.position = '0;
        case (op)
            spq_pkg::OP_INSERT:
            begin
                if (sorted_store.size() >= CAPACITY)
                    res.status = spq_pkg::STATUS_FULL;
                else
                begin
                    // new value goes ahead of equal entries
                    k = 0;
                    while (k < sorted_store.size() && sorted_store[k] < val)
                        k++;
                    sorted_store.insert(k, val);
                end
            end
            spq_pkg::OP_REMOVE:
            begin
                k = locate_value(val);
                if (k < 0)
                    res.status = spq_pkg::STATUS_NOT_FOUND;
                else
                begin
                    res.position = k[spq_pkg::POS_W-1:0];
                    sorted_store.delete(k);
                end
            end
            spq_pkg::OP_FIND:
            begin
                k = locate_value(val);
                if (k < 0)
                    res.status = spq_pkg::STATUS_NOT_FOUND;
                else
                    res.position = k[spq_pkg::POS_W-1:0];
            end
            default: ;
        endcase
        res.head_valid = (sorted_store.size() > 0);
        res.head_value = res.head_valid ? sorted_store[0] : '0;
        res.count      = spq_pkg::COUNT_W'(sorted_store.size());
        return res;
    endfunction

    task automatic push_cmd(spq_pkg::op_t op, logic signed [spq_pkg::DATA_W-1:0] val);
        queue_cmd_t c;
        c.pause = 1'b0;
        c.op    = op;
        c.value = val;
        cmd_backlog.push_back(c);
        planned_count++;
    endtask

    task automatic push_pause();
        queue_cmd_t c;
        c.pause = 1'b1;
        c.op    = spq_pkg::OP_PEEK;
        c.value = '0;
        cmd_backlog.push_back(c);
    endtask

    // Pick a value: mostly from a small pool so that matches and duplicates are common
    function automatic logic signed [spq_pkg::DATA_W-1:0] pick_value();
        int sel;
        sel = $urandom_range(99);
        if (sel < 60)
            return int'($urandom_range(9)) - 5;
        else if (sel < 75)
        begin
            case ($urandom_range(3))
                0:       return 32'sh8000_0000;
                1:       return 32'sh7FFF_FFFF;
                2:       return -1;
                default: return 0;
            endcase
        end
        return $urandom;
    endfunction

    // Build the stimulus and wait for the run to finish
    initial
    begin : stimulus_proc
        int seg_left;
        int ins_pct;
        int r;
        spq_pkg::op_t op;

        // empty queue cases
        push_cmd(spq_pkg::OP_PEEK, 32'sd77);
        push_cmd(spq_pkg::OP_REMOVE, 32'sd5);
        push_cmd(spq_pkg::OP_FIND, 32'sd5);
        // extremes and a duplicate
        push_cmd(spq_pkg::OP_INSERT, 32'sh7FFF_FFFF);
        push_cmd(spq_pkg::OP_INSERT, 32'sh8000_0000);
        push_cmd(spq_pkg::OP_INSERT, 32'sd0);
        push_cmd(spq_pkg::OP_INSERT, 32'sd0);
        push_cmd(spq_pkg::OP_FIND, 32'sd0);
        push_cmd(spq_pkg::OP_FIND, 32'sh7FFF_FFFF);
        push_cmd(spq_pkg::OP_REMOVE, 32'sd0);
        // fill to capacity, then insert into a full queue
        for (int i = 0; i < CAPACITY - 3; i++)
            push_cmd(spq_pkg::OP_INSERT, i - 5);
        push_cmd(spq_pkg::OP_INSERT, 32'sd1);
        push_cmd(spq_pkg::OP_PEEK, 32'shFFFF_FFFF);
        push_cmd(spq_pkg::OP_REMOVE, 32'sh8000_0000);
        push_pause();

        // random segments, each chosen at random to fill, drain or mix
        seg_left = 0;
        ins_pct  = 50;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (seg_left == 0)
            begin
                seg_left = $urandom_range(80, 40);
                case ($urandom_range(2))
                    0:       ins_pct = 80;
                    1:       ins_pct = 10;
                    default: ins_pct = 40;
                endcase
            end
            seg_left--;
            r = $urandom_range(99);
            if (r < ins_pct)
                op = spq_pkg::OP_INSERT;
            else
            begin
                r = $urandom_range(99);
                op = (r < 50) ? spq_pkg::OP_REMOVE :
                     (r < 85) ? spq_pkg::OP_FIND : spq_pkg::OP_PEEK;
            end
            push_cmd(op, pick_value());
            if (n % 300 == 299)
                push_pause();
        end

        @(posedge rst_n);
        while (cmd_backlog.size() > 0 || cmd_ch.valid || expected_results.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("[sorted_priority_queue_unit] OK");
        else
            $display("[sorted_priority_queue_unit] ERROR");
        $finish;
    end

    // Drive commands; predict each transaction as it is accepted
    always @(posedge clk or negedge rst_n)
    begin : drive_proc
        int         phase;
        int         idle_pct;
        queue_cmd_t c;
        if (!rst_n)
        begin
            cmd_ch.valid <= 1'b0;
            cmd_ch.op    <= spq_pkg::OP_PEEK;
            cmd_ch.value <= '0;
        end
        else
        begin
            if (cmd_ch.valid && cmd_ch.ready)
            begin
                expected_results.push_back(apply_queue_op(spq_pkg::op_t'(cmd_ch.op),
                                                          cmd_ch.value));
                accepted_count++;
            end
            phase    = (planned_count > 0) ? accepted_count * 3 / planned_count : 0;
            idle_pct = (phase == 0) ? 14 : (phase == 1) ? 74 : 0;
            if (!cmd_ch.valid || cmd_ch.ready)
            begin
                // release a pause once every expected result has come back
                if (cmd_backlog.size() > 0 && cmd_backlog[0].pause
                    && expected_results.size() == 0)
                    void'(cmd_backlog.pop_front());
                if (cmd_backlog.size() > 0 && !cmd_backlog[0].pause
                    && $urandom_range(99) >= idle_pct)
                begin
                    c = cmd_backlog.pop_front();
                    cmd_ch.valid <= 1'b1;
                    cmd_ch.op    <= c.op;
                    cmd_ch.value <= c.value;
                end
                else
                    cmd_ch.valid <= 1'b0;
            end
        end
    end

    // Accept results with random stalls and check them in order
    always @(posedge clk or negedge rst_n)
    begin : monitor_proc
        int            phase;
        int            stall_pct;
        queue_result_t exp_res;
        if (!rst_n)
            res_ch.ready <= 1'b0;
        else
        begin
            if (res_ch.valid && res_ch.ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("unexpected result transaction");
                    error_count++;
                end
                else
                begin
                    exp_res = expected_results.pop_front();
                    if (res_ch.status !== exp_res.status)
                    begin
                        $error("status: expected %0d, got %0d", exp_res.status, res_ch.status);
                        error_count++;
                    end
                    if (res_ch.position !== exp_res.position)
                    begin
                        $error("position: expected %0d, got %0d",
                               exp_res.position, res_ch.position);
                        error_count++;
                    end
                    if (res_ch.head_value !== exp_res.head_value)
                    begin
                        $error("head_value: expected %0d, got %0d",
                               exp_res.head_value, res_ch.head_value);
                        error_count++;
                    end
                    if (res_ch.head_valid !== exp_res.head_valid)
                    begin
                        $error("head_valid: expected %0d, got %0d",
                               exp_res.head_valid, res_ch.head_valid);
                        error_count++;
                    end
                    if (res_ch.count !== exp_res.count)
                    begin
                        $error("count: expected %0d, got %0d", exp_res.count, res_ch.count);
                        error_count++;
                    end
                end
            end
            phase     = (planned_count > 0) ? accepted_count * 3 / planned_count : 0;
            stall_pct = (phase == 0) ? 74 : (phase == 1) ? 14 : 0;
            res_ch.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // End the run if it hangs
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("[sorted_priority_queue_unit] ERROR");
            $finish;
        end
    end

endmodule

FILE: files.f
hw/rtl/spq_pkg.sv
hw/rtl/spq_cmd_if.sv
hw/rtl/spq_res_if.sv
hw/rtl/spq_cell.sv
hw/rtl/sorted_priority_queue_unit.sv
hw/rtl/spq_checker.sv
test/sorted_priority_queue_unit_tb.sv
